// ===== sv/bswg_pkg.sv =====
// ----------------------------------------------------------------------------
// bswg_pkg - shared types and constants for the burst square wave generator
// Field widths, command codes, prescaler tables and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package bswg_pkg;

  localparam int unsigned DEF_INPUT_CLOCK_HZ   = 16000000;
  localparam int unsigned DEF_MATCH_COUNT_BITS = 16;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned FREQ_W  = 23;
  localparam int unsigned PULSE_W = 15;
  localparam int unsigned TOP_W   = 8;
  localparam int unsigned SEL_W   = 3;
  localparam int unsigned PSC_W   = 10;
  localparam int unsigned SHIFT_W = 4;

  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BURST  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESUME = 3'd4;

  localparam logic [SEL_W-1:0] SEL_OFF     = 3'd0;
  localparam logic [SEL_W-1:0] SEL_DIV1    = 3'd1;
  localparam logic [SEL_W-1:0] SEL_DIV8    = 3'd2;
  localparam logic [SEL_W-1:0] SEL_DIV32   = 3'd3;
  localparam logic [SEL_W-1:0] SEL_DIV64   = 3'd4;
  localparam logic [SEL_W-1:0] SEL_DIV128  = 3'd5;
  localparam logic [SEL_W-1:0] SEL_DIV256  = 3'd6;
  localparam logic [SEL_W-1:0] SEL_DIV1024 = 3'd7;

  localparam logic [FREQ_W-1:0] FREQ_CLAMP = 23'd8000000;
  localparam logic [FREQ_W-1:0] THR_DIV1   = 23'd31373;
  localparam logic [FREQ_W-1:0] THR_DIV8   = 23'd3921;
  localparam logic [FREQ_W-1:0] THR_DIV32  = 23'd980;
  localparam logic [FREQ_W-1:0] THR_DIV64  = 23'd490;
  localparam logic [FREQ_W-1:0] THR_DIV128 = 23'd245;
  localparam logic [FREQ_W-1:0] THR_DIV256 = 23'd122;

  localparam logic [TOP_W-1:0] TOP_MAX = 8'd255;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } bswg_state_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;       // one-beat command (tick, stop, resume, ignored)
    logic div_start;  // latch frequency command, load divider
    logic div_step;   // one quotient bit
    logic finish;     // last divider step, commit frequency/burst
  } bswg_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slow_cmd;   // incoming beat needs the divider
    logic div_last;   // divider on its final step
  } bswg_sts_t;

  typedef struct packed {
    logic              wave_level;
    logic              clock_running;
    logic              burst_armed;
    logic              compare_match;
    logic              burst_done;
    logic [TOP_W-1:0]  half_period_top;
    logic [SEL_W-1:0]  clock_select;
  } bswg_res_t;

  // log2 of the prescaler division for each select code
  function automatic logic [SHIFT_W-1:0] div_shift(input logic [SEL_W-1:0] sel);
    logic [SHIFT_W-1:0] sh;
    unique case (sel)
      SEL_OFF:     sh = 4'd0;
      SEL_DIV1:    sh = 4'd0;
      SEL_DIV8:    sh = 4'd3;
      SEL_DIV32:   sh = 4'd5;
      SEL_DIV64:   sh = 4'd6;
      SEL_DIV128:  sh = 4'd7;
      SEL_DIV256:  sh = 4'd8;
      SEL_DIV1024: sh = 4'd10;
      default:     sh = 4'd0;
    endcase
    return sh;
  endfunction

  // smallest prescaler that keeps top within 8 bits
  function automatic logic [SEL_W-1:0] pick_select(input logic [FREQ_W-1:0] f);
    logic [SEL_W-1:0] sel;
    priority if (f >= THR_DIV1)   sel = SEL_DIV1;
    else if (f >= THR_DIV8)       sel = SEL_DIV8;
    else if (f >= THR_DIV32)      sel = SEL_DIV32;
    else if (f >= THR_DIV64)      sel = SEL_DIV64;
    else if (f >= THR_DIV128)     sel = SEL_DIV128;
    else if (f >= THR_DIV256)     sel = SEL_DIV256;
    else                          sel = SEL_DIV1024;
    return sel;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bswg_if.sv =====
// ----------------------------------------------------------------------------
// bswg_if - command and result channels
// Valid/ready channels; a beat moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface bswg_in_if;
  logic                           valid;
  logic                           ready;
  logic [bswg_pkg::KIND_W-1:0]    kind;
  logic [bswg_pkg::FREQ_W-1:0]    frequency_hz;
  logic [bswg_pkg::PULSE_W-1:0]   pulse_count;

  modport source (output valid, kind, frequency_hz, pulse_count, input ready);
  modport sink   (input valid, kind, frequency_hz, pulse_count, output ready);
endinterface

interface bswg_out_if;
  logic                           valid;
  logic                           ready;
  logic                           wave_level;
  logic                           clock_running;
  logic                           burst_armed;
  logic                           compare_match;
  logic                           burst_done;
  logic [bswg_pkg::TOP_W-1:0]     half_period_top;
  logic [bswg_pkg::SEL_W-1:0]     clock_select;

  modport source (output valid, wave_level, clock_running, burst_armed, compare_match,
                  burst_done, half_period_top, clock_select, input ready);
  modport sink   (input valid, wave_level, clock_running, burst_armed, compare_match,
                  burst_done, half_period_top, clock_select, output ready);
endinterface

`default_nettype wire

// ===== sv/burst_square_wave_generator_unit.sv =====
// ----------------------------------------------------------------------------
// burst_square_wave_generator_unit - timer-driven square wave / pulse bursts
//
//   channel  dir  per beat
//   in_ch    in   kind, frequency_hz, pulse_count
//   out_ch   out  wave_level, clock_running, burst_armed, compare_match,
//                 burst_done, half_period_top, clock_select
//
// Tick, stop, resume and ignored commands are handled without the divider, so ticks
// stream one per clock while out_ch keeps up.
// Set frequency and burst run the restoring divider for the top value, which
// retires one bit per cycle; no new command beat is taken while it runs.
// Exactly one result beat per command beat; the result register holds while
// out_ch stalls and in_ch is taken again in the same cycle it drains.
// Synchronous active-low reset clears all timer state; no warm-up is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module burst_square_wave_generator_unit #(
  parameter int unsigned INPUT_CLOCK_HZ   = bswg_pkg::DEF_INPUT_CLOCK_HZ,
  parameter int unsigned MATCH_COUNT_BITS = bswg_pkg::DEF_MATCH_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  bswg_in_if.sink    in_ch,
  bswg_out_if.source out_ch
);
  import bswg_pkg::*;

  bswg_cmd_t cmd;
  bswg_sts_t sts;
  bswg_res_t res;

  bswg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bswg_dp #(
    .INPUT_CLOCK_HZ   (INPUT_CLOCK_HZ),
    .MATCH_COUNT_BITS (MATCH_COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .kind         (in_ch.kind),
    .frequency_hz (in_ch.frequency_hz),
    .pulse_count  (in_ch.pulse_count),
    .sts          (sts),
    .res          (res)
  );

  assign out_ch.wave_level      = res.wave_level;
  assign out_ch.clock_running   = res.clock_running;
  assign out_ch.burst_armed     = res.burst_armed;
  assign out_ch.compare_match   = res.compare_match;
  assign out_ch.burst_done      = res.burst_done;
  assign out_ch.half_period_top = res.half_period_top;
  assign out_ch.clock_select    = res.clock_select;

  // burst completion only comes from a compare match
  a_done_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.burst_done |-> out_ch.compare_match)
    else $error("burst_done without compare_match");

  // a finished burst leaves the clock stopped and counting disarmed
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.burst_done |-> !out_ch.clock_running && !out_ch.burst_armed)
    else $error("burst_done with clock still running or armed");

  // no new beat is taken while the divider is busy
  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !in_ch.ready)
    else $error("input accepted during divide");

  // a frequency command ends with a running clock
  a_finish_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_ch.valid && out_ch.clock_running && !out_ch.compare_match)
    else $error("frequency command did not start the clock");

endmodule

`default_nettype wire

// ===== sv/bswg_ctrl.sv =====
// ----------------------------------------------------------------------------
// bswg_ctrl - beat sequencer
// Accepts command beats, runs the divider for frequency commands and owns the
// result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bswg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bswg_pkg::bswg_sts_t sts,
  output bswg_pkg::bswg_cmd_t cmd
);
  import bswg_pkg::*;

  bswg_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // result slot is free or being drained this cycle
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          if (sts.slow_cmd) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end else begin
            cmd.exec = 1'b1;
            out_load = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.finish = 1'b1;
          out_load   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (out_load) out_valid_nxt = 1'b1;
    else if (out_ready)    out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/bswg_dp.sv =====
// ----------------------------------------------------------------------------
// bswg_dp - timer, prescaler, burst counter and top divider
// Holds all timer state; a restoring divider yields one quotient bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module bswg_dp #(
  parameter int unsigned INPUT_CLOCK_HZ   = bswg_pkg::DEF_INPUT_CLOCK_HZ,
  parameter int unsigned MATCH_COUNT_BITS = bswg_pkg::DEF_MATCH_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bswg_pkg::bswg_cmd_t           cmd,
  input  logic [bswg_pkg::KIND_W-1:0]   kind,
  input  logic [bswg_pkg::FREQ_W-1:0]   frequency_hz,
  input  logic [bswg_pkg::PULSE_W-1:0]  pulse_count,
  output bswg_pkg::bswg_sts_t           sts,
  output bswg_pkg::bswg_res_t           res
);
  import bswg_pkg::*;

  localparam int unsigned NW    = $clog2(INPUT_CLOCK_HZ + 1);
  localparam int unsigned CW    = $clog2(NW);
  localparam int unsigned MCB   = MATCH_COUNT_BITS;
  localparam int unsigned TGT_W = (MCB > PULSE_W + 1) ? MCB : PULSE_W + 1;
  localparam int unsigned RW    = FREQ_W + 1;
  localparam logic [NW-1:0]    CLK_N    = NW'(INPUT_CLOCK_HZ);
  localparam logic [TGT_W-1:0] MC_MAX_W = TGT_W'({MCB{1'b1}});

  // timer state
  logic [SEL_W-1:0]  saved_r, saved_nxt;
  logic [SEL_W-1:0]  active_r, active_nxt;
  logic [TOP_W-1:0]  top_r, top_nxt;
  logic [TOP_W-1:0]  timer_r, timer_nxt;
  logic [PSC_W-1:0]  psc_r, psc_nxt;
  logic              level_r, level_nxt;
  logic              armed_r, armed_nxt;
  logic [MCB-1:0]    mc_r, mc_nxt;
  logic [MCB-1:0]    target_r, target_nxt;
  logic              match_r, match_nxt;
  logic              done_r, done_nxt;

  // pending frequency command and divider
  logic [FREQ_W-1:0] f_r, f_nxt;
  logic [SEL_W-1:0]  code_r, code_nxt;
  logic              burst_r, burst_nxt;
  logic [MCB-1:0]    tgt_r, tgt_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [NW-1:0]     nq_r, nq_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  logic [FREQ_W-1:0]  f_cl;
  logic [SEL_W-1:0]   code_in;
  logic [SHIFT_W-1:0] shamt;
  logic [TGT_W-1:0]   tgt_raw;
  logic [MCB-1:0]     tgt_sat;
  logic [RW-1:0]      rem_sh, rem_new;
  logic               q_bit;
  logic [NW-1:0]      nq_new;
  logic [TOP_W-1:0]   top_fin;
  logic [PSC_W-1:0]   psc_inc, psc_mask;
  logic               advance;
  logic [MCB-1:0]     mc_inc;

  // command decode
  assign f_cl    = (frequency_hz > FREQ_CLAMP) ? FREQ_CLAMP : frequency_hz;
  assign code_in = pick_select(f_cl);
  assign shamt   = div_shift(code_in) + 4'd1;
  assign tgt_raw = TGT_W'({pulse_count, 1'b0});
  assign tgt_sat = (tgt_raw > MC_MAX_W) ? MC_MAX_W[MCB-1:0] : tgt_raw[MCB-1:0];

  assign sts.slow_cmd = ((kind == KIND_SET) && (frequency_hz != '0)) ||
                        ((kind == KIND_BURST) && (frequency_hz != '0) &&
                         (pulse_count != '0));
  assign sts.div_last = (cnt_r == CW'(NW - 1));

  // restoring divide step: floor(clk / (2*div*f)) = floor((clk >> (log2 div + 1)) / f)
  assign rem_sh  = {rem_r[RW-2:0], nq_r[NW-1]};
  assign q_bit   = (rem_sh >= {1'b0, f_r});
  assign rem_new = q_bit ? (rem_sh - {1'b0, f_r}) : rem_sh;
  assign nq_new  = {nq_r[NW-2:0], q_bit};

  always_comb begin
    priority if (nq_new == '0)          top_fin = '0;
    else if (nq_new > NW'(TOP_MAX) + 1) top_fin = TOP_MAX;
    else                                top_fin = TOP_W'(nq_new - NW'(1));
  end

  // prescaler and timer
  assign psc_inc  = psc_r + PSC_W'(1);
  assign psc_mask = PSC_W'((11'd1 << div_shift(active_r)) - 11'd1);
  assign advance  = (active_r != SEL_OFF) && ((psc_inc & psc_mask) == '0);
  assign mc_inc   = mc_r + MCB'(1);

  always_comb begin
    saved_nxt  = saved_r;
    active_nxt = active_r;
    top_nxt    = top_r;
    timer_nxt  = timer_r;
    psc_nxt    = psc_r;
    level_nxt  = level_r;
    armed_nxt  = armed_r;
    mc_nxt     = mc_r;
    target_nxt = target_r;
    match_nxt  = match_r;
    done_nxt   = done_r;
    f_nxt      = f_r;
    code_nxt   = code_r;
    burst_nxt  = burst_r;
    tgt_nxt    = tgt_r;
    rem_nxt    = rem_r;
    nq_nxt     = nq_r;
    cnt_nxt    = cnt_r;

    if (cmd.exec) begin
      match_nxt = 1'b0;
      done_nxt  = 1'b0;
      unique case (kind)
        KIND_TICK: begin
          psc_nxt = psc_inc;
          if (advance) begin
            if (timer_r == top_r) begin
              timer_nxt = '0;
              level_nxt = ~level_r;
              match_nxt = 1'b1;
              if (armed_r) begin
                mc_nxt = mc_inc;
                if (mc_inc >= target_r) begin
                  armed_nxt  = 1'b0;
                  active_nxt = SEL_OFF;
                  mc_nxt     = '0;
                  done_nxt   = 1'b1;
                end
              end
            end else begin
              timer_nxt = timer_r + TOP_W'(1);
            end
          end
        end
        KIND_STOP:   active_nxt = SEL_OFF;
        KIND_RESUME: active_nxt = saved_r;
        default: ;  // zero-operand commands and unused kinds
      endcase
    end

    if (cmd.div_start) begin
      f_nxt     = f_cl;
      code_nxt  = code_in;
      burst_nxt = (kind == KIND_BURST);
      tgt_nxt   = tgt_sat;
      rem_nxt   = '0;
      nq_nxt    = CLK_N >> shamt;
      cnt_nxt   = '0;
    end

    if (cmd.div_step) begin
      rem_nxt = rem_new;
      nq_nxt  = nq_new;
      cnt_nxt = cnt_r + CW'(1);
    end

    if (cmd.finish) begin
      saved_nxt  = code_r;
      active_nxt = code_r;
      top_nxt    = top_fin;
      match_nxt  = 1'b0;
      done_nxt   = 1'b0;
      if (burst_r) begin
        mc_nxt     = '0;
        target_nxt = tgt_r;
        armed_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saved_r  <= SEL_OFF;
      active_r <= SEL_OFF;
      top_r    <= '0;
      timer_r  <= '0;
      psc_r    <= '0;
      level_r  <= 1'b0;
      armed_r  <= 1'b0;
      mc_r     <= '0;
      target_r <= '0;
      match_r  <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      saved_r  <= saved_nxt;
      active_r <= active_nxt;
      top_r    <= top_nxt;
      timer_r  <= timer_nxt;
      psc_r    <= psc_nxt;
      level_r  <= level_nxt;
      armed_r  <= armed_nxt;
      mc_r     <= mc_nxt;
      target_r <= target_nxt;
      match_r  <= match_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_r     <= f_nxt;
    code_r  <= code_nxt;
    burst_r <= burst_nxt;
    tgt_r   <= tgt_nxt;
    rem_r   <= rem_nxt;
    nq_r    <= nq_nxt;
    cnt_r   <= cnt_nxt;
  end

  // state only changes when a result is loaded, so it doubles as the payload
  assign res.wave_level      = level_r;
  assign res.clock_running   = (active_r != SEL_OFF);
  assign res.burst_armed     = armed_r;
  assign res.compare_match   = match_r;
  assign res.burst_done      = done_r;
  assign res.half_period_top = top_r;
  assign res.clock_select    = active_r;

endmodule

`default_nettype wire
